// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CKD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ckd assertion failed");

// Next-cycle implication.
`define CKD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ckd assertion failed");

`endif

// ===== rtl/core/ckd_pkg.sv =====
// ----------------------------------------------------------------------------
// ckd_pkg
// Types, constants and chord tables for the chord keyboard decoder.
// ----------------------------------------------------------------------------
package ckd_pkg;

  localparam int NumKeys  = 6;
  localparam int CntW     = 4;
  localparam int CharW    = 7;

  typedef enum logic [1:0] {
    MODE_UPPER  = 2'd0,
    MODE_LOWER  = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_SYMBOL = 2'd3
  } mode_e;

  // Fixed chords, used only when the mode table has no entry
  localparam logic [NumKeys-1:0] CHORD_CAPS   = 6'd1;
  localparam logic [NumKeys-1:0] CHORD_BKSP   = 6'd13;
  localparam logic [NumKeys-1:0] CHORD_SYMBOL = 6'd17;
  localparam logic [NumKeys-1:0] CHORD_LOWER  = 6'd21;
  localparam logic [NumKeys-1:0] CHORD_NUMBER = 6'd25;
  localparam logic [NumKeys-1:0] CHORD_RETURN = 6'd44;

  localparam logic [CharW-1:0] CH_NONE      = 7'h00;
  localparam logic [CharW-1:0] CH_BACKSPACE = 7'h7f;
  localparam logic [CharW-1:0] CH_RETURN    = 7'h0a;
  localparam logic [CharW-1:0] CH_LC_A      = 7'h61;
  localparam logic [CharW-1:0] CH_LC_Z      = 7'h7a;
  localparam logic [CharW-1:0] CASE_OFFSET  = 7'h20;

  typedef struct packed {
    logic press;
    logic release_;
  } lane_evt_t;

  typedef struct packed {
    logic                 chord_valid;
    logic [NumKeys-1:0]   chord;
    logic [CharW-1:0]     char_code;
    mode_e                mode;
  } res_t;

  function automatic logic [CharW-1:0] letter_lookup(input logic [NumKeys-1:0] code);
    logic [CharW-1:0] c;
    unique case (code)
      6'd12: c = 7'h61;  6'd56: c = 7'h62;  6'd10: c = 7'h63;  6'd14: c = 7'h64;
      6'd4:  c = 7'h65;  6'd30: c = 7'h66;  6'd48: c = 7'h67;  6'd34: c = 7'h68;
      6'd6:  c = 7'h69;  6'd50: c = 7'h6a;  6'd18: c = 7'h6b;  6'd38: c = 7'h6c;
      6'd60: c = 7'h6d;  6'd24: c = 7'h6e;  6'd8:  c = 7'h6f;  6'd62: c = 7'h70;
      6'd40: c = 7'h71;  6'd22: c = 7'h72;  6'd16: c = 7'h73;  6'd20: c = 7'h74;
      6'd32: c = 7'h75;  6'd36: c = 7'h76;  6'd54: c = 7'h77;  6'd58: c = 7'h78;
      6'd26: c = 7'h79;  6'd42: c = 7'h7a;  6'd2:  c = 7'h20;  6'd52: c = 7'h2c;
      6'd28: c = 7'h2e;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // Chord 52 gives a closing brace here, as the original table has it.
  function automatic logic [CharW-1:0] number_lookup(input logic [NumKeys-1:0] code);
    logic [CharW-1:0] c;
    unique case (code)
      6'd8:  c = 7'h30;  6'd2:  c = 7'h31;  6'd6:  c = 7'h32;  6'd14: c = 7'h33;
      6'd30: c = 7'h34;  6'd62: c = 7'h35;  6'd32: c = 7'h36;  6'd48: c = 7'h37;
      6'd56: c = 7'h38;  6'd60: c = 7'h39;  6'd52: c = 7'h7d;  6'd28: c = 7'h2e;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] symbol_lookup(input logic [NumKeys-1:0] code);
    logic [CharW-1:0] c;
    unique case (code)
      6'd2:  c = 7'h20;  6'd52: c = 7'h2c;  6'd28: c = 7'h2e;  6'd54: c = 7'h2c;
      6'd50: c = 7'h3b;  6'd42: c = 7'h25;  6'd4:  c = 7'h3d;  6'd22: c = 7'h26;
      6'd14: c = 7'h28;  6'd56: c = 7'h29;  6'd16: c = 7'h24;  6'd12: c = 7'h40;
      6'd62: c = 7'h2b;  6'd34: c = 7'h23;  6'd24: c = 7'h2d;  6'd58: c = 7'h21;
      6'd26: c = 7'h3f;  6'd18: c = 7'h2f;  6'd30: c = 7'h7b;  6'd60: c = 7'h7d;
      6'd10: c = 7'h5b;  6'd40: c = 7'h5d;  6'd36: c = 7'h5c;  6'd20: c = 7'h2a;
      6'd6:  c = 7'h3c;  6'd48: c = 7'h3e;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] decode_in_mode(input mode_e m,
                                                      input logic [NumKeys-1:0] code);
    logic [CharW-1:0] c;
    unique case (m)
      MODE_UPPER: begin
        c = letter_lookup(code);
        if (c >= CH_LC_A && c <= CH_LC_Z) c = c - CASE_OFFSET;
      end
      MODE_LOWER:  c = letter_lookup(code);
      MODE_NUMBER: c = number_lookup(code);
      MODE_SYMBOL: c = symbol_lookup(code);
      default:     c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/ckd_lane.sv =====
// ----------------------------------------------------------------------------
// ckd_lane
// Debounce lane for one key: accepted level, change counter, press/release.
// ----------------------------------------------------------------------------
module ckd_lane (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    level_i,
  input  logic [ckd_pkg::CntW-1:0] debounce_i,
  output ckd_pkg::lane_evt_t      evt_o
);

  logic                     level_q, level_d;
  logic [ckd_pkg::CntW-1:0] count_q, count_d;
  logic [ckd_pkg::CntW-1:0] count_inc;
  logic                     differs;
  logic                     fire;

  always_comb begin
    differs   = level_i != level_q;
    count_inc = count_q + 4'd1;
    // a count of zero behaves like one: the compare always passes
    fire      = differs && (count_inc >= debounce_i);
    if (!differs || fire) begin
      count_d = '0;
    end else begin
      count_d = count_inc;
    end
    level_d        = fire ? level_i : level_q;
    evt_o.press    = fire && !level_i;
    evt_o.release_ = fire && level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b1;
      count_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== rtl/core/ckd_merge.sv =====
// ----------------------------------------------------------------------------
// ckd_merge
// Merges lane events in key order into the held chord, decodes a finished
// chord and tracks the keyboard mode.
// ----------------------------------------------------------------------------
module ckd_merge (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     en_i,
  input  ckd_pkg::lane_evt_t [ckd_pkg::NumKeys-1:0] evt_i,
  output ckd_pkg::res_t                            res_o
);

  logic [ckd_pkg::NumKeys-1:0] held_q, held_d;
  logic                        asm_q, asm_d;
  ckd_pkg::mode_e              mode_q, mode_d;
  logic [ckd_pkg::NumKeys-1:0] result;
  logic [ckd_pkg::CharW-1:0]   ch;

  always_comb begin
    held_d = held_q;
    asm_d  = asm_q;
    result = '0;
    for (int i = 0; i < ckd_pkg::NumKeys; i++) begin
      if (evt_i[i].press) begin
        if (held_d == '0) asm_d = 1'b1;
        held_d[i] = 1'b1;
      end else if (evt_i[i].release_) begin
        if (asm_d) begin
          result = held_d;
          asm_d  = 1'b0;
        end
        held_d[i] = 1'b0;
      end
    end
  end

  always_comb begin
    mode_d = mode_q;
    ch     = ckd_pkg::CH_NONE;
    if (result != '0) begin
      ch = ckd_pkg::decode_in_mode(mode_q, result);
      if (ch == ckd_pkg::CH_NONE) begin
        unique case (result)
          ckd_pkg::CHORD_CAPS: begin
            if (mode_q == ckd_pkg::MODE_UPPER) begin
              mode_d = ckd_pkg::MODE_LOWER;
            end else if (mode_q == ckd_pkg::MODE_LOWER) begin
              mode_d = ckd_pkg::MODE_UPPER;
            end
          end
          ckd_pkg::CHORD_BKSP:   ch = ckd_pkg::CH_BACKSPACE;
          ckd_pkg::CHORD_SYMBOL: mode_d = ckd_pkg::MODE_SYMBOL;
          ckd_pkg::CHORD_LOWER:  mode_d = ckd_pkg::MODE_LOWER;
          ckd_pkg::CHORD_NUMBER: mode_d = ckd_pkg::MODE_NUMBER;
          ckd_pkg::CHORD_RETURN: ch = ckd_pkg::CH_RETURN;
          default: ;
        endcase
      end
    end
    res_o.chord_valid = result != '0;
    res_o.chord       = result;
    res_o.char_code   = ch;
    res_o.mode        = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      asm_q  <= 1'b0;
      mode_q <= ckd_pkg::MODE_LOWER;
    end else if (en_i) begin
      held_q <= held_d;
      asm_q  <= asm_d;
      mode_q <= mode_d;
    end
  end

endmodule

// ===== rtl/core/chord_keyboard_decoder.sv =====
// ----------------------------------------------------------------------------
// chord_keyboard_decoder
// Six-key chord keyboard decoder: per-key debounce, chord assembly, decode.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / key_levels_i): one transfer per
//   poll tick, six raw key levels, a level of 0 means pressed.
//   Output channel (out_valid_o / out_stall_i): exactly one result per tick:
//   chord_valid_o, chord_o, char_code_o and mode_now_o.
//   Config: cfg_we_i writes cfg_wdata_i into the debounce count (reset 1);
//   write only while the block is idle.
//   Output: a result is registered into the output register on its input
//   transfer, or into the skid register if stalled. Throughput: one tick per
//   cycle while in_stall_o is low, limited by the lane update and merge path.
//   Stall: a stalled result is held in the output register and the next one
//   goes into a skid register, so one more tick is taken; in_stall_o rises
//   only once the skid register is full.
//   Reset: all keys released, counters clear, no chord held, lower-case
//   mode, debounce count 1, output empty.
// ----------------------------------------------------------------------------
module chord_keyboard_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [ckd_pkg::CntW-1:0]     cfg_wdata_i,
  // poll ticks in
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ckd_pkg::NumKeys-1:0]  key_levels_i,
  // results out
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         chord_valid_o,
  output logic [ckd_pkg::NumKeys-1:0]  chord_o,
  output logic [ckd_pkg::CharW-1:0]    char_code_o,
  output logic [1:0]                   mode_now_o
);

  logic [ckd_pkg::CntW-1:0] debounce_q;
  logic                     accept;
  logic                     out_fire;

  ckd_pkg::lane_evt_t [ckd_pkg::NumKeys-1:0] evt;
  ckd_pkg::res_t                             res;

  // output register plus skid stage
  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  ckd_pkg::res_t out_q, out_d;
  ckd_pkg::res_t skid_q, skid_d;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign out_fire   = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= 4'd1;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  // one debounce lane per key, all updating on the same transfer
  for (genvar g = 0; g < ckd_pkg::NumKeys; g++) begin : g_lane
    ckd_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .en_i       (accept),
      .level_i    (key_levels_i[g]),
      .debounce_i (debounce_q),
      .evt_o      (evt[g])
    );
  end

  // events are folded in key order, then the finished chord is decoded
  ckd_merge u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .evt_i  (evt),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      // no transfer possible; drain the skid into the output register
      if (out_fire) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || out_fire) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o   = out_valid_q;
  assign chord_valid_o = out_q.chord_valid;
  assign chord_o       = out_q.chord;
  assign char_code_o   = out_q.char_code;
  assign mode_now_o    = out_q.mode;

endmodule

// ===== rtl/core/ckd_checker.sv =====
// ----------------------------------------------------------------------------
// ckd_checker
// Port-level checks for the chord keyboard decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ckd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         chord_valid_o,
  input logic [ckd_pkg::NumKeys-1:0]  chord_o,
  input logic [ckd_pkg::CharW-1:0]    char_code_o,
  input logic [1:0]                   mode_now_o
);

  // no chord means no character and an empty key set
  `CKD_ASSERT_IMPL(a_no_chord_no_char, out_valid_o && !chord_valid_o,
                   chord_o == '0 && char_code_o == '0)

  // a completed chord always names at least one key
  `CKD_ASSERT_IMPL(a_chord_nonempty, out_valid_o && chord_valid_o, chord_o != '0)

  // input back-pressure only once a result is already waiting
  `CKD_ASSERT_IMPL(a_stall_needs_result, in_stall_o, out_valid_o)

  // a stalled result is held
  `CKD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(chord_o) && $stable(char_code_o)
                   && $stable(mode_now_o) && $stable(chord_valid_o))

endmodule

bind chord_keyboard_decoder ckd_checker u_ckd_checker (.*);

// ===== verif/chord_keyboard_decoder_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord keyboard decoder checker
// Watches both channels and the debounce register writes. It keeps its own
// model of debounce, chord assembly and mode decode, and compares every
// result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module chord_keyboard_decoder_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ckd_pkg::CntW-1:0]     cfg_wdata_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [ckd_pkg::NumKeys-1:0]  key_levels_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         chord_valid_i,
  input  logic [ckd_pkg::NumKeys-1:0]  chord_i,
  input  logic [ckd_pkg::CharW-1:0]    char_code_i,
  input  logic [1:0]                   mode_now_i,
  output int                           pending_o,
  output int                           fail_count_o
);
  import ckd_pkg::*;

  localparam logic [CntW-1:0] DEBOUNCE_RESET = 4'd1;

  // Character per chord code for each table, 0 where the table has no entry
  logic [7:0] letter_of [64];
  logic [7:0] number_of [64];
  logic [7:0] symbol_of [64];

  // Model state
  logic [CntW-1:0]    debounce_len;
  logic [NumKeys-1:0] key_up;
  logic [CntW-1:0]    bounce_run [NumKeys];
  logic [NumKeys-1:0] held_keys;
  logic               chord_open;
  mode_e              cur_mode;

  res_t tick_results_q[$];
  res_t want;

  initial begin
    for (int c = 0; c < 64; c++) begin
      letter_of[c] = 8'd0;
      number_of[c] = 8'd0;
      symbol_of[c] = 8'd0;
    end
    letter_of[12] = "a"; letter_of[56] = "b"; letter_of[10] = "c"; letter_of[14] = "d";
    letter_of[4]  = "e"; letter_of[30] = "f"; letter_of[48] = "g"; letter_of[34] = "h";
    letter_of[6]  = "i"; letter_of[50] = "j"; letter_of[18] = "k"; letter_of[38] = "l";
    letter_of[60] = "m"; letter_of[24] = "n"; letter_of[8]  = "o"; letter_of[62] = "p";
    letter_of[40] = "q"; letter_of[22] = "r"; letter_of[16] = "s"; letter_of[20] = "t";
    letter_of[32] = "u"; letter_of[36] = "v"; letter_of[54] = "w"; letter_of[58] = "x";
    letter_of[26] = "y"; letter_of[42] = "z"; letter_of[2]  = " "; letter_of[52] = ",";
    letter_of[28] = ".";
    number_of[8]  = "0"; number_of[2]  = "1"; number_of[6]  = "2"; number_of[14] = "3";
    number_of[30] = "4"; number_of[62] = "5"; number_of[32] = "6"; number_of[48] = "7";
    number_of[56] = "8"; number_of[60] = "9"; number_of[52] = "}"; number_of[28] = ".";
    symbol_of[2]  = " "; symbol_of[52] = ","; symbol_of[28] = "."; symbol_of[54] = ",";
    symbol_of[50] = ";"; symbol_of[42] = "%"; symbol_of[4]  = "="; symbol_of[22] = "&";
    symbol_of[14] = "("; symbol_of[56] = ")"; symbol_of[16] = "$"; symbol_of[12] = "@";
    symbol_of[62] = "+"; symbol_of[34] = "#"; symbol_of[24] = "-"; symbol_of[58] = "!";
    symbol_of[26] = "?"; symbol_of[18] = "/"; symbol_of[30] = "{"; symbol_of[60] = "}";
    symbol_of[10] = "["; symbol_of[40] = "]"; symbol_of[36] = "\\"; symbol_of[20] = "*";
    symbol_of[6]  = "<"; symbol_of[48] = ">";
  end

  // One poll tick: debounce each key in index order, then decode a finished chord
  function automatic res_t poll_tick(input logic [NumKeys-1:0] levels);
    res_t               r;
    logic [NumKeys-1:0] done;
    logic [NumKeys-1:0] prior;
    logic [7:0]         c;
    done = '0;
    c    = 8'd0;
    for (int k = 0; k < NumKeys; k++) begin
      if (levels[k] == key_up[k]) begin
        bounce_run[k] = '0;
      end else begin
        bounce_run[k] = bounce_run[k] + 1'b1;
        if (bounce_run[k] >= debounce_len) begin
          bounce_run[k] = '0;
          key_up[k]     = levels[k];
          if (!levels[k]) begin
            if (held_keys == '0) chord_open = 1'b1;
            held_keys[k] = 1'b1;
          end else begin
            prior        = held_keys;
            held_keys[k] = 1'b0;
            // only the first release of an open chord completes it
            if (chord_open) begin
              done       = prior;
              chord_open = 1'b0;
            end
          end
        end
      end
    end

    if (done != '0) begin
      case (cur_mode)
        MODE_UPPER: begin
          c = letter_of[done];
          if (c >= "a" && c <= "z") c = c - 8'd32;
        end
        MODE_LOWER:  c = letter_of[done];
        MODE_NUMBER: c = number_of[done];
        default:     c = symbol_of[done];
      endcase
      if (c == 8'd0) begin
        case (done)
          CHORD_CAPS: begin
            if (cur_mode == MODE_UPPER) cur_mode = MODE_LOWER;
            else if (cur_mode == MODE_LOWER) cur_mode = MODE_UPPER;
          end
          CHORD_BKSP:   c = {1'b0, CH_BACKSPACE};
          CHORD_SYMBOL: cur_mode = MODE_SYMBOL;
          CHORD_LOWER:  cur_mode = MODE_LOWER;
          CHORD_NUMBER: cur_mode = MODE_NUMBER;
          CHORD_RETURN: c = {1'b0, CH_RETURN};
          default: ;
        endcase
      end
    end

    r.chord_valid = (done != '0);
    r.chord       = done;
    r.char_code   = c[CharW-1:0];
    r.mode        = cur_mode;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_len = DEBOUNCE_RESET;
      key_up       = '1;
      held_keys    = '0;
      chord_open   = 1'b0;
      cur_mode     = MODE_LOWER;
      for (int k = 0; k < NumKeys; k++) bounce_run[k] = '0;
      tick_results_q.delete();
      fail_count_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) debounce_len = cfg_wdata_i;

      // result leaving now belongs to an earlier tick, so check before predicting
      if (out_valid_i && !out_stall_i) begin
        if (tick_results_q.size() == 0) begin
          $error("result transfer with no tick outstanding");
          fail_count_o++;
        end else begin
          want = tick_results_q.pop_front();
          if (chord_valid_i !== want.chord_valid) begin
            $error("chord_valid: expected %0d, got %0d", want.chord_valid, chord_valid_i);
            fail_count_o++;
          end
          if (chord_i !== want.chord) begin
            $error("chord: expected %0d, got %0d", want.chord, chord_i);
            fail_count_o++;
          end
          if (char_code_i !== want.char_code) begin
            $error("char_code: expected 0x%02h, got 0x%02h", want.char_code, char_code_i);
            fail_count_o++;
          end
          if (mode_now_i !== 2'(want.mode)) begin
            $error("mode_now: expected %0d, got %0d", want.mode, mode_now_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) tick_results_q.push_back(poll_tick(key_levels_i));
      pending_o <= tick_results_q.size();
    end
  end

endmodule

// ===== verif/chord_keyboard_decoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chord keyboard decoder testbench
// Types chords on the six keys under a range of debounce counts, mixing
// clean strokes, staggered presses and releases, bounce and raw noise, with
// random idling on both channels and one long output hold-off. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module chord_keyboard_decoder_test;
  import ckd_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  // Block inputs
  logic                cfg_we;
  logic [CntW-1:0]     cfg_wdata;
  logic                in_valid;
  logic [NumKeys-1:0]  key_levels;
  logic                out_stall;

  // Block outputs
  logic                in_stall;
  logic                out_valid;
  logic                chord_valid;
  logic [NumKeys-1:0]  chord;
  logic [CharW-1:0]    char_code;
  logic [1:0]          mode_now;

  int pending;
  int failures;

  // Shared between the sender and the receiver
  bit quiet    = 1'b0;   // no idling on either side while set
  bit hold_req = 1'b0;   // receiver takes one long hold-off when it sees this
  int ticks_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  chord_keyboard_decoder DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .key_levels_i  (key_levels),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .chord_valid_o (chord_valid),
    .chord_o       (chord),
    .char_code_o   (char_code),
    .mode_now_o    (mode_now)
  );

  chord_keyboard_decoder_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .key_levels_i  (key_levels),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .chord_valid_i (chord_valid),
    .chord_i       (chord),
    .char_code_i   (char_code),
    .mode_now_i    (mode_now),
    .pending_o     (pending),
    .fail_count_o  (failures)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one poll tick and hold it until the transfer happens. Valid is left
  // high afterwards so back-to-back ticks need no second assignment in the
  // same step; the idle loop or drain() lowers it.
  task automatic send_tick(input logic [NumKeys-1:0] levels);
    while (!quiet && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    key_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Stop offering and wait for every outstanding result, then let the output
  // register settle.
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_debounce(input logic [CntW-1:0] count);
    drain(2);
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // One keystroke: press the chord, hold for dwell polls, release. A messy
  // stroke may put keys down or lift them one at a time from a random
  // starting key, and may throw in a single bounce poll between the two.
  task automatic strike(input logic [NumKeys-1:0] keys, input int dwell, input bit messy);
    logic [NumKeys-1:0] lv;
    int                 first;
    int                 j;
    first = $urandom_range(NumKeys - 1);
    if (messy && $urandom_range(3) == 0) begin
      lv = '1;
      for (int k = 0; k < NumKeys; k++) begin
        j = (first + k) % NumKeys;
        if (keys[j]) begin
          lv[j] = 1'b0;
          repeat (dwell) send_tick(lv);
        end
      end
    end else begin
      repeat (dwell) send_tick(~keys);
    end

    if (messy && $urandom_range(4) == 0) send_tick(NumKeys'($urandom_range(63)));

    if (messy && $urandom_range(3) == 0) begin
      lv = ~keys;
      for (int k = 0; k < NumKeys; k++) begin
        j = (first + k) % NumKeys;
        if (keys[j]) begin
          lv[j] = 1'b1;
          repeat (dwell) send_tick(lv);
        end
      end
    end else begin
      repeat (dwell) send_tick('1);
    end
  endtask

  // Fixed chords come up often so that modes change frequently; the rest is
  // any non-empty key set.
  function automatic logic [NumKeys-1:0] pick_chord();
    if ($urandom_range(9) < 4) begin
      case ($urandom_range(5))
        0:       return CHORD_CAPS;
        1:       return CHORD_BKSP;
        2:       return CHORD_SYMBOL;
        3:       return CHORD_LOWER;
        4:       return CHORD_NUMBER;
        default: return CHORD_RETURN;
      endcase
    end
    return NumKeys'($urandom_range(1, 63));
  endfunction

  initial begin : stimulus
    logic [CntW-1:0] db;
    int              stop_at;
    int              dwell;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    key_levels = '1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening at the reset debounce count: lower-case letter, caps
    // toggle into upper case, number mode with the brace quirk, backspace, symbol
    // mode, return, back to lower case and the all-keys chord that matches
    // nothing.
    strike(6'd12, 1, 1'b0);
    strike(CHORD_CAPS, 1, 1'b0);
    strike(6'd12, 1, 1'b0);
    strike(CHORD_NUMBER, 1, 1'b0);
    strike(6'd52, 1, 1'b0);
    strike(CHORD_BKSP, 1, 1'b0);
    strike(CHORD_SYMBOL, 1, 1'b0);
    strike(CHORD_RETURN, 1, 1'b0);
    strike(CHORD_LOWER, 1, 1'b0);
    strike(6'd63, 1, 1'b0);
    // key 0 lifts while key 1 goes down in the same poll: the release closes
    // the first chord and the press opens a fresh one
    send_tick(6'h3e);
    send_tick(6'h3d);
    send_tick(6'h3f);

    // Random phases, each under its own debounce count. Zero behaves as
    // immediate acceptance; fifteen is the slow extreme.
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       db = 4'd0;
        1:       db = 4'd2;
        2:       db = 4'd15;
        3:       db = 4'd1;
        4:       db = 4'd3;
        5:       db = CntW'($urandom_range(1, 15));
        default: db = 4'd1;
      endcase
      set_debounce(db);
      quiet = (p == 3);
      if (p == 1) hold_req = 1'b1;
      stop_at = ticks_sent + 140;
      while (ticks_sent < stop_at) begin
        dwell = (db == 0 ? 1 : int'(db)) + $urandom_range(1);
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 4)) send_tick(NumKeys'($urandom_range(63)));
        end else begin
          strike(pick_chord(), dwell, 1'b1);
        end
      end
      quiet = 1'b0;
    end

    drain(4);
    if (failures == 0) begin
      $display("chord_keyboard_decoder_test: clean");
    end else begin
      $display("chord_keyboard_decoder_test: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side
  // --------------------------------------------------------------------------

  // Random stalls, except for one long hold-off when asked: the block fills
  // its output and skid registers and then stalls the sender.
  initial begin : receiver
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 23);
      end
    end
  end

  // Watchdog: well beyond the slowest legal run
  initial begin : watchdog
    #1600000;
    $display("chord_keyboard_decoder_test: errors");
    $finish;
  end

endmodule
